@@ sv/buddy_block_allocator_macros.svh @@
// assertion macros for the buddy block allocator
// expects clk and rst_n in the scope of use
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BBA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bba implication check failed");

// antecedent implies consequent in the next cycle
`define BBA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bba next-cycle check failed");

`endif

@@ sv/bba_pkg.sv @@
// shared types and constants for the buddy block allocator
// no dependencies
`default_nettype none

package bba_pkg;

    localparam int ORDER_W  = 5;
    localparam int DATA_W   = 16;
    localparam int STATUS_W = 2;
    localparam int BYTES_W  = 17;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_NOMEM   = 2'd1,
        ST_BADFREE = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_A_SRCH,
        S_A_POP,
        S_A_NWR,
        S_SPLIT,
        S_PUSH,
        S_PUSH_WR,
        S_F_CHK,
        S_F_HDR,
        S_M_TOP,
        S_M_CHK,
        S_M_PWR,
        S_M_NRD,
        S_M_NWR,
        S_M_HI
    } state_t;

endpackage

`default_nettype wire

@@ sv/bba_hdr_mem.sv @@
// unit header memory: one write port, one registered read port
// read-during-write to the same entry returns the new data
`default_nettype none

module bba_hdr_mem #(
    parameter int AW = 11,
    parameter int DW = 31
) (
    input  wire logic          clk,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/bba_ctrl.sv @@
// buddy allocator sequencer: free list heads, split and merge control
// depends on bba_pkg and buddy_block_allocator_macros.svh; drives bba_hdr_mem
`default_nettype none

`include "buddy_block_allocator_macros.svh"

module bba_ctrl
    import bba_pkg::*;
#(
    parameter int MAX_POOL_ORDER  = 16,
    parameter int MIN_BLOCK_ORDER = 5,
    parameter int HEADER_BYTES    = 32,
    localparam int IW = MAX_POOL_ORDER - MIN_BLOCK_ORDER,
    localparam int UW = IW + 1,
    localparam int WW = 2 + ORDER_W + 2 * UW
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [ORDER_W-1:0]  cfg_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                cmd,
    input  wire logic [DATA_W-1:0]   req_size,
    input  wire logic [DATA_W-1:0]   free_offset,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [STATUS_W-1:0]      status,
    output logic [DATA_W-1:0]        user_offset,
    output logic                     mem_re,
    output logic [IW-1:0]            mem_raddr,
    input  wire logic [WW-1:0]       mem_rdata,
    output logic                     mem_we,
    output logic [IW-1:0]            mem_waddr,
    output logic [WW-1:0]            mem_wdata
);

    localparam int NH = MAX_POOL_ORDER + 1;
    localparam int HW = $clog2(NH);
    localparam int OW = ((MAX_POOL_ORDER > DATA_W) ? MAX_POOL_ORDER : DATA_W) + 1;
    localparam logic [UW-1:0] NIL = UW'(1 << IW);
    localparam int RST_ORDER = (16 > MAX_POOL_ORDER) ? MAX_POOL_ORDER :
                               ((16 < MIN_BLOCK_ORDER) ? MIN_BLOCK_ORDER : 16);
    localparam logic [ORDER_W-1:0] MIN_ORD = ORDER_W'(MIN_BLOCK_ORDER);
    localparam logic [ORDER_W-1:0] MAX_ORD = ORDER_W'(MAX_POOL_ORDER);

    function automatic logic [WW-1:0] mk_word(
        input logic               hd,
        input logic               fr,
        input logic [ORDER_W-1:0] od,
        input logic [UW-1:0]      nx,
        input logic [UW-1:0]      pv
    );
        mk_word = {hd, fr, od, nx, pv};
    endfunction

    state_t               state_reg, state_next;
    logic [ORDER_W-1:0]   pool_order_reg, pool_order_next;
    logic [IW-1:0]        clr_reg, clr_next;
    logic                 cmd_reg, cmd_next;
    logic [DATA_W-1:0]    req_reg, req_next;
    logic [DATA_W-1:0]    foff_reg, foff_next;
    logic [ORDER_W-1:0]   want_reg, want_next;
    logic [ORDER_W-1:0]   ord_reg, ord_next;
    logic [IW-1:0]        u_reg, u_next;
    logic [IW-1:0]        bud_reg, bud_next;
    logic [UW-1:0]        n_reg, n_next;
    logic [UW-1:0]        p_reg, p_next;
    logic [UW-1:0]        hsave_reg, hsave_next;
    logic [IW-1:0]        push_unit_reg, push_unit_next;
    logic [ORDER_W-1:0]   push_ord_reg, push_ord_next;
    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [DATA_W-1:0]    offset_reg, offset_next;
    logic [UW-1:0]        heads_reg [NH];

    logic                 heads_we;
    logic [HW-1:0]        heads_widx;
    logic [UW-1:0]        heads_wdata;
    logic                 heads_init;
    logic [ORDER_W-1:0]   heads_init_ord;

    // decoded memory word
    logic                 rd_head, rd_free;
    logic [ORDER_W-1:0]   rd_order;
    logic [UW-1:0]        rd_next, rd_prev;

    logic [BYTES_W-1:0]   bytes_m1;
    logic [ORDER_W-1:0]   want_c;
    logic                 found_c;
    logic [ORDER_W-1:0]   sel_c;
    logic [OW-1:0]        foff_w, off_w;
    logic                 foff_ok;
    logic [UW-1:0]        push_h;
    logic [ORDER_W-1:0]   cfg_clamped;
    logic [OW-1:0]        alloc_off;

    assign rd_head  = mem_rdata[WW-1];
    assign rd_free  = mem_rdata[WW-2];
    assign rd_order = mem_rdata[WW-3 -: ORDER_W];
    assign rd_next  = mem_rdata[2*UW-1 -: UW];
    assign rd_prev  = mem_rdata[UW-1:0];

    assign cfg_ready   = 1'b1;
    assign in_ready    = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign user_offset = offset_reg;

    always_comb
    begin
        if (cfg_data < MIN_ORD)
        begin
            cfg_clamped = MIN_ORD;
        end
        else if (cfg_data > MAX_ORD)
        begin
            cfg_clamped = MAX_ORD;
        end
        else
        begin
            cfg_clamped = cfg_data;
        end
    end

    // order of the rounded request: ceil(log2(req + header)), at least the minimum
    always_comb
    begin
        bytes_m1 = BYTES_W'(req_reg) + BYTES_W'(HEADER_BYTES) - BYTES_W'(1);
        want_c   = MIN_ORD;
        for (int k = 0; k < BYTES_W; k++)
        begin
            if (bytes_m1[k] && (ORDER_W'(k + 1) > MIN_ORD))
            begin
                want_c = ORDER_W'(k + 1);
            end
        end
    end

    // lowest non-empty list at or above the wanted order
    always_comb
    begin
        found_c = 1'b0;
        sel_c   = '0;
        for (int k = NH - 1; k >= 0; k--)
        begin
            if ((ORDER_W'(k) >= want_reg) && (ORDER_W'(k) <= pool_order_reg) &&
                (heads_reg[k] != NIL))
            begin
                found_c = 1'b1;
                sel_c   = ORDER_W'(k);
            end
        end
    end

    always_comb
    begin
        foff_w  = OW'(foff_reg);
        off_w   = foff_w - OW'(HEADER_BYTES);
        foff_ok = (foff_w >= OW'(HEADER_BYTES)) &&
                  (off_w[MIN_BLOCK_ORDER-1:0] == '0) &&
                  ((off_w >> pool_order_reg) == '0);
    end

    assign push_h    = heads_reg[push_ord_reg[HW-1:0]];
    assign alloc_off = (OW'(u_reg) << MIN_BLOCK_ORDER) + OW'(HEADER_BYTES);

    always_comb
    begin
        state_next      = state_reg;
        pool_order_next = pool_order_reg;
        clr_next        = clr_reg;
        cmd_next        = cmd_reg;
        req_next        = req_reg;
        foff_next       = foff_reg;
        want_next       = want_reg;
        ord_next        = ord_reg;
        u_next          = u_reg;
        bud_next        = bud_reg;
        n_next          = n_reg;
        p_next          = p_reg;
        hsave_next      = hsave_reg;
        push_unit_next  = push_unit_reg;
        push_ord_next   = push_ord_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        offset_next     = offset_reg;
        heads_we        = 1'b0;
        heads_widx      = '0;
        heads_wdata     = NIL;
        heads_init      = 1'b0;
        heads_init_ord  = cfg_clamped;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                if (clr_reg == '0)
                begin
                    mem_wdata = mk_word(1'b1, 1'b1, pool_order_reg, NIL, NIL);
                end
                else
                begin
                    mem_wdata = mk_word(1'b0, 1'b0, '0, NIL, NIL);
                end
                clr_next = clr_reg + IW'(1);
                if (clr_reg == {IW{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd_next   = cmd;
                    req_next   = req_size;
                    foff_next  = free_offset;
                    state_next = (cmd == CMD_FREE) ? S_F_CHK : S_A_SRCH;
                end
            end
            S_A_SRCH:
            begin
                want_next = want_c;
                if (want_c > pool_order_reg)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_NOMEM;
                    offset_next    = '0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_A_POP;
                end
            end
            S_A_POP:
            begin
                // first cycle after want is known: pick list, read its head
                if (!found_c)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_NOMEM;
                    offset_next    = '0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    ord_next   = sel_c;
                    u_next     = heads_reg[sel_c[HW-1:0]][IW-1:0];
                    mem_re     = 1'b1;
                    mem_raddr  = heads_reg[sel_c[HW-1:0]][IW-1:0];
                    state_next = S_A_NWR;
                    n_next     = NIL;
                    hsave_next = '0;
                end
            end
            S_A_NWR:
            begin
                if (hsave_reg == '0)
                begin
                    // header of the popped block: unlink it and mark it used
                    mem_we      = 1'b1;
                    mem_waddr   = u_reg;
                    mem_wdata   = mk_word(1'b1, 1'b0, want_reg, NIL, NIL);
                    heads_we    = 1'b1;
                    heads_widx  = ord_reg[HW-1:0];
                    heads_wdata = rd_next;
                    n_next      = rd_next;
                    hsave_next  = UW'(1);
                    if (rd_next != NIL)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = rd_next[IW-1:0];
                    end
                    else
                    begin
                        state_next = S_SPLIT;
                    end
                end
                else
                begin
                    // new list head gets a null prev
                    mem_we     = 1'b1;
                    mem_waddr  = n_reg[IW-1:0];
                    mem_wdata  = {mem_rdata[WW-1:UW], NIL};
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                if (ord_reg > want_reg)
                begin
                    ord_next       = ord_reg - ORDER_W'(1);
                    push_ord_next  = ord_reg - ORDER_W'(1);
                    push_unit_next = u_reg +
                        (IW'(1) << (ord_reg - ORDER_W'(1) - MIN_ORD));
                    state_next     = S_PUSH;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_DONE;
                    offset_next    = alloc_off[DATA_W-1:0];
                    state_next     = S_IDLE;
                end
            end
            S_PUSH:
            begin
                mem_we      = 1'b1;
                mem_waddr   = push_unit_reg;
                mem_wdata   = mk_word(1'b1, 1'b1, push_ord_reg, push_h, NIL);
                heads_we    = 1'b1;
                heads_widx  = push_ord_reg[HW-1:0];
                heads_wdata = UW'(push_unit_reg);
                hsave_next  = push_h;
                if (push_h != NIL)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = push_h[IW-1:0];
                    state_next = S_PUSH_WR;
                end
                else if (cmd_reg == CMD_FREE)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_DONE;
                    offset_next    = '0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_SPLIT;
                end
            end
            S_PUSH_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = hsave_reg[IW-1:0];
                mem_wdata = {mem_rdata[WW-1:UW], UW'(push_unit_reg)};
                if (cmd_reg == CMD_FREE)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_DONE;
                    offset_next    = '0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_SPLIT;
                end
            end
            S_F_CHK:
            begin
                if (foff_ok)
                begin
                    u_next     = off_w[MIN_BLOCK_ORDER +: IW];
                    mem_re     = 1'b1;
                    mem_raddr  = off_w[MIN_BLOCK_ORDER +: IW];
                    state_next = S_F_HDR;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_BADFREE;
                    offset_next    = '0;
                    state_next     = S_IDLE;
                end
            end
            S_F_HDR:
            begin
                if (rd_head && !rd_free && (rd_order >= MIN_ORD) &&
                    (rd_order <= pool_order_reg))
                begin
                    ord_next   = rd_order;
                    state_next = S_M_TOP;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_BADFREE;
                    offset_next    = '0;
                    state_next     = S_IDLE;
                end
            end
            S_M_TOP:
            begin
                if (ord_reg < pool_order_reg)
                begin
                    bud_next   = u_reg ^ (IW'(1) << (ord_reg - MIN_ORD));
                    mem_re     = 1'b1;
                    mem_raddr  = u_reg ^ (IW'(1) << (ord_reg - MIN_ORD));
                    state_next = S_M_CHK;
                end
                else
                begin
                    push_unit_next = u_reg;
                    push_ord_next  = ord_reg;
                    state_next     = S_PUSH;
                end
            end
            S_M_CHK:
            begin
                if (rd_head && rd_free && (rd_order == ord_reg))
                begin
                    n_next = rd_next;
                    p_next = rd_prev;
                    if (rd_prev != NIL)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = rd_prev[IW-1:0];
                        state_next = S_M_PWR;
                    end
                    else
                    begin
                        heads_we    = 1'b1;
                        heads_widx  = ord_reg[HW-1:0];
                        heads_wdata = rd_next;
                        state_next  = S_M_NRD;
                    end
                end
                else
                begin
                    push_unit_next = u_reg;
                    push_ord_next  = ord_reg;
                    state_next     = S_PUSH;
                end
            end
            S_M_PWR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = p_reg[IW-1:0];
                mem_wdata  = {mem_rdata[WW-1:2*UW], n_reg, mem_rdata[UW-1:0]};
                state_next = S_M_NRD;
            end
            S_M_NRD:
            begin
                if (n_reg != NIL)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = n_reg[IW-1:0];
                    state_next = S_M_NWR;
                end
                else
                begin
                    state_next = S_M_HI;
                end
            end
            S_M_NWR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = n_reg[IW-1:0];
                mem_wdata  = {mem_rdata[WW-1:UW], p_reg};
                state_next = S_M_HI;
            end
            S_M_HI:
            begin
                // upper block of the pair loses its header
                mem_we     = 1'b1;
                mem_waddr  = (u_reg < bud_reg) ? bud_reg : u_reg;
                mem_wdata  = mk_word(1'b0, 1'b0, '0, NIL, NIL);
                u_next     = (u_reg < bud_reg) ? u_reg : bud_reg;
                ord_next   = ord_reg + ORDER_W'(1);
                state_next = S_M_TOP;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready)
        begin
            pool_order_next = cfg_clamped;
            heads_init      = 1'b1;
            heads_init_ord  = cfg_clamped;
            clr_next        = '0;
            state_next      = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            pool_order_reg <= ORDER_W'(RST_ORDER);
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
            for (int k = 0; k < NH; k++)
            begin
                heads_reg[k] <= (k == RST_ORDER) ? '0 : NIL;
            end
        end
        else
        begin
            state_reg      <= state_next;
            pool_order_reg <= pool_order_next;
            clr_reg        <= clr_next;
            out_valid_reg  <= out_valid_next;
            if (heads_init)
            begin
                for (int k = 0; k < NH; k++)
                begin
                    heads_reg[k] <= (ORDER_W'(k) == heads_init_ord) ? '0 : NIL;
                end
            end
            else if (heads_we)
            begin
                heads_reg[heads_widx] <= heads_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        req_reg       <= req_next;
        foff_reg      <= foff_next;
        want_reg      <= want_next;
        ord_reg       <= ord_next;
        u_reg         <= u_next;
        bud_reg       <= bud_next;
        n_reg         <= n_next;
        p_reg         <= p_next;
        hsave_reg     <= hsave_next;
        push_unit_reg <= push_unit_next;
        push_ord_reg  <= push_ord_next;
        status_reg    <= status_next;
        offset_reg    <= offset_next;
    end

    `BBA_ASSERT_NXT(a_leave_idle, in_valid && in_ready && !cfg_valid, !in_ready)
    `BBA_ASSERT_IMP(a_result_in_idle, out_valid_reg, state_reg == S_IDLE)
    `BBA_ASSERT_IMP(a_fail_zero_off, out_valid_reg && (status_reg != ST_DONE), offset_reg == '0)
    `BBA_ASSERT_IMP(a_no_item_in_clear, state_reg == S_CLEAR, !in_ready)
    `BBA_ASSERT_IMP(a_order_range, (pool_order_reg >= MIN_ORD), (pool_order_reg <= MAX_ORD))

endmodule

`default_nettype wire

@@ sv/buddy_block_allocator.sv @@
// buddy block allocator top: bba_ctrl sequencer plus bba_hdr_mem, types from bba_pkg
// alloc: order search, list pick and head read, header write and unlink, successor
// prev fix if any, a split and push per halving; oversize or no free block ends early
// free: offset and header checks (a bad offset ends there), a merge per level, a push
// one item at a time, the next is taken the cycle after the result transfer
// reset and each pool_order write start a clear of all 2^(MAX_POOL_ORDER-MIN_BLOCK_ORDER) entries
`default_nettype none

module buddy_block_allocator
    import bba_pkg::*;
#(
    parameter int MAX_POOL_ORDER  = 16,
    parameter int MIN_BLOCK_ORDER = 5,
    parameter int HEADER_BYTES    = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [ORDER_W-1:0]  cfg_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                cmd,
    input  wire logic [DATA_W-1:0]   req_size,
    input  wire logic [DATA_W-1:0]   free_offset,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [STATUS_W-1:0]      status,
    output logic [DATA_W-1:0]        user_offset
);

    localparam int IW = MAX_POOL_ORDER - MIN_BLOCK_ORDER;
    localparam int WW = 2 + ORDER_W + 2 * (IW + 1);

    logic          mem_re, mem_we;
    logic [IW-1:0] mem_raddr, mem_waddr;
    logic [WW-1:0] mem_rdata, mem_wdata;

    bba_ctrl #(
        .MAX_POOL_ORDER  (MAX_POOL_ORDER),
        .MIN_BLOCK_ORDER (MIN_BLOCK_ORDER),
        .HEADER_BYTES    (HEADER_BYTES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .req_size    (req_size),
        .free_offset (free_offset),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .user_offset (user_offset),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata)
    );

    bba_hdr_mem #(
        .AW (IW),
        .DW (WW)
    ) u_hdr_mem (
        .clk   (clk),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata)
    );

endmodule

`default_nettype wire
